// File: rtl/phrr_pkg.sv
// Shared types and constants of the palm-to-hand rotated rectangle block.
// Used by the queue, the front and the back; depends on nothing.
package phrr_pkg;

  // Angle constants: Q3.13 for the output angle, 2^-16 rad inside the CORDICs
  localparam logic signed [17:0] HALF_PI_Q13      = 18'sd12868;
  localparam logic signed [17:0] PI_Q13           = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13       = 18'sd51472;
  localparam logic signed [19:0] QUARTER_TURN_Q16 = 20'sd102944;
  localparam logic signed [19:0] HALF_TURN_Q16    = 20'sd205888;

  // Rotation CORDIC start value and unit, Q.30
  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30  = 33'sd1073741824;

  // Arctangent table, 2^-16 rad
  localparam int ATAN_N = 25;
  localparam logic [16:0] ATAN_Q16 [ATAN_N] = '{
    17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024,
    17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
    17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  // Register reset values
  localparam logic [15:0] HAND_SCALE_RST = 16'd10650;
  localparam logic [12:0] SHIFT_X_RST    = 13'h0000;
  localparam logic [12:0] SHIFT_Y_RST    = 13'h1800;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef enum logic [1:0] {
    CFG_HAND_SCALE = 2'd0,
    CFG_SHIFT_X    = 2'd1,
    CFG_SHIFT_Y    = 2'd2
  } cfg_idx_t;

  // Item as classified by the front
  typedef struct packed {
    logic [24:0] dx;
    logic [24:0] dy;
    logic        zero;
    logic [24:0] pcx;
    logic [24:0] pcy;
    logic [25:0] ox;
    logic [25:0] oy;
    logic [22:0] size;
  } front_item_t;

  // Fields carried alongside the angle pipeline
  typedef struct packed {
    logic [24:0] pcx;
    logic [24:0] pcy;
    logic [25:0] ox;
    logic [25:0] oy;
    logic [22:0] size;
  } carry_t;

  // Vectoring CORDIC stage
  typedef struct packed {
    logic [43:0] x;
    logic [43:0] y;
    logic [19:0] z;
    logic        zero;
  } vec_t;

  // Rotation CORDIC stage
  typedef struct packed {
    logic [32:0] x;
    logic [32:0] y;
    logic [19:0] z;
    logic        neg;
    logic        azero;
    logic [15:0] ang;
  } rot_t;

endpackage

// File: rtl/phrr_if.sv
// Valid/ready channel interfaces of the palm-to-hand rotated rectangle block.
// Standalone; no package needed.
interface phrr_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] box_left;
  logic signed [23:0] box_top;
  logic signed [23:0] box_right;
  logic signed [23:0] box_bottom;
  logic signed [23:0] wrist_x;
  logic signed [23:0] wrist_y;
  logic signed [23:0] finger_base_x;
  logic signed [23:0] finger_base_y;

  modport source (
    output valid, box_left, box_top, box_right, box_bottom,
    output wrist_x, wrist_y, finger_base_x, finger_base_y,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_right, box_bottom,
    input  wrist_x, wrist_y, finger_base_x, finger_base_y,
    output ready
  );
endinterface

interface phrr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic signed [23:0] hand_center_x;
  logic signed [23:0] hand_center_y;
  logic        [22:0] hand_size;
  logic signed [23:0] corner0_x;
  logic signed [23:0] corner0_y;
  logic signed [23:0] corner1_x;
  logic signed [23:0] corner1_y;
  logic signed [23:0] corner2_x;
  logic signed [23:0] corner2_y;
  logic signed [23:0] corner3_x;
  logic signed [23:0] corner3_y;

  modport source (
    output valid, angle, hand_center_x, hand_center_y, hand_size,
    output corner0_x, corner0_y, corner1_x, corner1_y,
    output corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );
  modport sink (
    input  valid, angle, hand_center_x, hand_center_y, hand_size,
    input  corner0_x, corner0_y, corner1_x, corner1_y,
    input  corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

// File: rtl/phrr_fifo.sv
// Short item queue between the front and the back.
// Depends on phrr_pkg for the item type and depth.
module phrr_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  phrr_pkg::front_item_t   push_item,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output phrr_pkg::front_item_t   pop_item
);

  phrr_pkg::front_item_t              mem_r [phrr_pkg::QUEUE_DEPTH];
  logic [phrr_pkg::QUEUE_AW-1:0]      wr_ptr_r;
  logic [phrr_pkg::QUEUE_AW-1:0]      rd_ptr_r;
  logic [phrr_pkg::QUEUE_AW:0]        count_r;
  logic                               push;
  logic                               pop;

  assign push_ready = (count_r != (phrr_pkg::QUEUE_AW+1)'(phrr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

// File: rtl/phrr_front.sv
// Front of the palm-to-hand rectangle: accepts palms, forms the keypoint
// vector, box size and center, center offset and hand size. Uses phrr_pkg.
module phrr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  phrr_in_if.sink               in_chan,
  input  logic [15:0]           hand_scale,
  input  logic signed [12:0]    center_shift_x,
  input  logic signed [12:0]    center_shift_y,
  output logic                  q_valid,
  input  logic                  q_ready,
  output phrr_pkg::front_item_t q_item
);

  logic                  f1_v_r;
  logic signed [24:0]    dx_r, dy_r, w_r, h_r, pcx_r, pcy_r, longs_r;
  logic signed [24:0]    dx_nxt, dy_nxt, w_nxt, h_nxt, pcx_nxt, pcy_nxt, longs_nxt;
  logic                  f2_v_r;
  phrr_pkg::front_item_t f2_item_r;
  phrr_pkg::front_item_t f2_item_nxt;
  logic                  f1_take;
  logic                  f2_take;
  logic signed [37:0]    ox_prod, oy_prod;
  logic signed [41:0]    size_prod;
  logic signed [29:0]    size_q;

  assign f2_take       = !f2_v_r || q_ready;
  assign f1_take       = !f1_v_r || f2_take;
  assign in_chan.ready = f1_take;
  assign q_valid       = f2_v_r;
  assign q_item        = f2_item_r;

  // Form differences, box center and long side
  always_comb begin
    w_nxt   = $signed({in_chan.box_right[23], in_chan.box_right})
            - $signed({in_chan.box_left[23], in_chan.box_left});
    h_nxt   = $signed({in_chan.box_bottom[23], in_chan.box_bottom})
            - $signed({in_chan.box_top[23], in_chan.box_top});
    pcx_nxt = $signed({in_chan.box_left[23], in_chan.box_left}) + (w_nxt >>> 1);
    pcy_nxt = $signed({in_chan.box_top[23], in_chan.box_top}) + (h_nxt >>> 1);
    dx_nxt  = $signed({in_chan.finger_base_x[23], in_chan.finger_base_x})
            - $signed({in_chan.wrist_x[23], in_chan.wrist_x});
    dy_nxt  = $signed({in_chan.wrist_y[23], in_chan.wrist_y})
            - $signed({in_chan.finger_base_y[23], in_chan.finger_base_y});
    longs_nxt = (w_nxt > h_nxt) ? w_nxt : h_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (f1_take) begin
      f1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_take) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      pcx_r   <= pcx_nxt;
      pcy_r   <= pcy_nxt;
      longs_r <= longs_nxt;
    end
  end

  // Scale offset and hand size, round half up at bit 12
  always_comb begin
    ox_prod   = w_r * center_shift_x + 38'sd2048;
    oy_prod   = h_r * center_shift_y + 38'sd2048;
    size_prod = longs_r * $signed({1'b0, hand_scale}) + 42'sd2048;
    size_q    = size_prod[41:12];
    f2_item_nxt.dx   = dx_r;
    f2_item_nxt.dy   = dy_r;
    f2_item_nxt.zero = (dx_r == '0) && (dy_r == '0);
    f2_item_nxt.pcx  = pcx_r;
    f2_item_nxt.pcy  = pcy_r;
    f2_item_nxt.ox   = ox_prod[37:12];
    f2_item_nxt.oy   = oy_prod[37:12];
    if (size_q[29]) begin
      f2_item_nxt.size = '0;
    end else if (size_q > 30'sd8388607) begin
      f2_item_nxt.size = 23'h7FFFFF;
    end else begin
      f2_item_nxt.size = size_q[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (f2_take) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_take) f2_item_r <= f2_item_nxt;
  end

endmodule

// File: rtl/phrr_back.sv
// Back of the palm-to-hand rectangle: atan2 and sin/cos CORDIC pipelines,
// then the rotation products, rounding and saturation. Uses phrr_pkg.
module phrr_back #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  phrr_pkg::front_item_t in_item,
  phrr_out_if.source            out_chan
);

  localparam int N = CORDIC_STAGES;

  logic adv;

  // Vectoring pipeline
  phrr_pkg::vec_t   vec_r   [0:N];
  phrr_pkg::vec_t   vec_nxt [0:N];
  phrr_pkg::carry_t vcar_r  [0:N];
  logic [N:0]       vec_v_r;
  logic signed [43:0] x_e, y_e, vxs, vys;

  // Angle stage
  logic               ang_v_r;
  logic [15:0]        ang_r;
  logic [15:0]        ang_nxt;
  phrr_pkg::carry_t   acar_r;
  logic signed [19:0] at_rnd;
  logic signed [16:0] at_q;
  logic signed [17:0] ang_raw, ang_wr;

  // Rotation pipeline
  phrr_pkg::rot_t   rot_r   [0:N];
  phrr_pkg::rot_t   rot_nxt [0:N];
  phrr_pkg::carry_t rcar_r  [0:N];
  logic [N:0]       rot_v_r;
  logic signed [19:0] za;
  logic signed [32:0] rxs, rys;

  // Sine/cosine stage
  logic               sc_v_r;
  logic signed [32:0] s_r, c_r, s_nxt, c_nxt;
  logic [15:0]        sc_ang_r;
  phrr_pkg::carry_t   scar_r;

  // Product stage
  logic               m1_v_r;
  logic signed [58:0] oxc_r, oys_r, oxs_r, oyc_r;
  logic signed [55:0] dc_r, ds_r;
  logic [24:0]        m1_pcx_r, m1_pcy_r;
  logic [15:0]        m1_ang_r;
  logic [22:0]        m1_size_r;
  logic [21:0]        half_side;

  // Center stage
  logic               m2_v_r;
  logic signed [23:0] hcx_r, hcy_r, hcx_nxt, hcy_nxt;
  logic signed [27:0] ra_r, rna_r, rb_r, rnb_r;
  logic [15:0]        m2_ang_r;
  logic [22:0]        m2_size_r;
  logic signed [59:0] sumx, sumy, tx, ty;
  logic signed [57:0] sa, sb;

  // Output register
  logic               out_v_r;
  logic signed [23:0] out_hcx_r, out_hcy_r;
  logic signed [23:0] c0x_r, c0y_r, c1x_r, c1y_r, c2x_r, c2y_r, c3x_r, c3y_r;
  logic [15:0]        out_ang_r;
  logic [22:0]        out_size_r;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sh007FFFFF) return 24'sh7FFFFF;
    else if (v < 32'shFF800000) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic signed [27:0] rnd30(input logic signed [57:0] v);
    logic signed [57:0] t;
    t = v + 58'sd536870912;
    return t[57:30];
  endfunction

  function automatic logic signed [23:0] add_sat(input logic signed [23:0] a,
                                                 input logic signed [27:0] b);
    return sat24($signed({{8{a[23]}}, a}) + $signed({{4{b[27]}}, b}));
  endfunction

  // Stall the whole pipeline only while a result waits
  assign adv      = !out_v_r || out_chan.ready;
  assign in_ready = adv;

  // Fold the keypoint vector into the right half plane, then iterate
  always_comb begin
    x_e = $signed({{3{in_item.dx[24]}}, in_item.dx, 16'b0});
    y_e = $signed({{3{in_item.dy[24]}}, in_item.dy, 16'b0});
    vec_nxt[0].zero = in_item.zero;
    if (in_item.dx[24]) begin
      if (!in_item.dy[24]) begin
        vec_nxt[0].x = y_e;
        vec_nxt[0].y = -x_e;
        vec_nxt[0].z = phrr_pkg::QUARTER_TURN_Q16;
      end else begin
        vec_nxt[0].x = -y_e;
        vec_nxt[0].y = x_e;
        vec_nxt[0].z = -phrr_pkg::QUARTER_TURN_Q16;
      end
    end else begin
      vec_nxt[0].x = x_e;
      vec_nxt[0].y = y_e;
      vec_nxt[0].z = '0;
    end
    vxs = '0;
    vys = '0;
    for (int k = 0; k < N; k++) begin
      vxs = $signed(vec_r[k].x) >>> k;
      vys = $signed(vec_r[k].y) >>> k;
      vec_nxt[k+1].zero = vec_r[k].zero;
      if (!vec_r[k].y[43]) begin
        vec_nxt[k+1].x = vec_r[k].x + vys;
        vec_nxt[k+1].y = vec_r[k].y - vxs;
        vec_nxt[k+1].z = vec_r[k].z + {3'b0, phrr_pkg::ATAN_Q16[k]};
      end else begin
        vec_nxt[k+1].x = vec_r[k].x - vys;
        vec_nxt[k+1].y = vec_r[k].y + vxs;
        vec_nxt[k+1].z = vec_r[k].z - {3'b0, phrr_pkg::ATAN_Q16[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_v_r <= '0;
    end else if (adv) begin
      vec_v_r <= {vec_v_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) vec_r[k] <= vec_nxt[k];
      vcar_r[0] <= '{pcx: in_item.pcx, pcy: in_item.pcy, ox: in_item.ox,
                     oy: in_item.oy, size: in_item.size};
      for (int k = 1; k <= N; k++) vcar_r[k] <= vcar_r[k-1];
    end
  end

  // Round atan2 to Q3.13, subtract from pi/2 and wrap to [-pi, pi)
  always_comb begin
    at_rnd = $signed(vec_r[N].z) + 20'sd4;
    at_q   = at_rnd[19:3];
    if (vec_r[N].zero) begin
      ang_raw = phrr_pkg::HALF_PI_Q13;
    end else begin
      ang_raw = phrr_pkg::HALF_PI_Q13 - $signed({at_q[16], at_q});
    end
    if (ang_raw >= phrr_pkg::PI_Q13) begin
      ang_wr = ang_raw - phrr_pkg::TWO_PI_Q13;
    end else if (ang_raw < -phrr_pkg::PI_Q13) begin
      ang_wr = ang_raw + phrr_pkg::TWO_PI_Q13;
    end else begin
      ang_wr = ang_raw;
    end
    if (ang_wr > phrr_pkg::PI_Q13 - 18'sd1) begin
      ang_nxt = 16'sd25735;
    end else if (ang_wr < -phrr_pkg::PI_Q13) begin
      ang_nxt = -16'sd25736;
    end else begin
      ang_nxt = ang_wr[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_v_r <= 1'b0;
    end else if (adv) begin
      ang_v_r <= vec_v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r  <= ang_nxt;
      acar_r <= vcar_r[N];
    end
  end

  // Fold the angle into [-pi/2, pi/2], then rotate the gain vector
  always_comb begin
    za = $signed({ang_r[15], ang_r, 3'b0});
    rot_nxt[0].x     = phrr_pkg::GAIN_Q30;
    rot_nxt[0].y     = '0;
    rot_nxt[0].azero = (ang_r == '0);
    rot_nxt[0].ang   = ang_r;
    if (za > phrr_pkg::QUARTER_TURN_Q16) begin
      rot_nxt[0].z   = za - phrr_pkg::HALF_TURN_Q16;
      rot_nxt[0].neg = 1'b1;
    end else if (za < -phrr_pkg::QUARTER_TURN_Q16) begin
      rot_nxt[0].z   = za + phrr_pkg::HALF_TURN_Q16;
      rot_nxt[0].neg = 1'b1;
    end else begin
      rot_nxt[0].z   = za;
      rot_nxt[0].neg = 1'b0;
    end
    rxs = '0;
    rys = '0;
    for (int k = 0; k < N; k++) begin
      rxs = $signed(rot_r[k].x) >>> k;
      rys = $signed(rot_r[k].y) >>> k;
      rot_nxt[k+1].neg   = rot_r[k].neg;
      rot_nxt[k+1].azero = rot_r[k].azero;
      rot_nxt[k+1].ang   = rot_r[k].ang;
      if (!rot_r[k].z[19]) begin
        rot_nxt[k+1].x = rot_r[k].x - rys;
        rot_nxt[k+1].y = rot_r[k].y + rxs;
        rot_nxt[k+1].z = rot_r[k].z - {3'b0, phrr_pkg::ATAN_Q16[k]};
      end else begin
        rot_nxt[k+1].x = rot_r[k].x + rys;
        rot_nxt[k+1].y = rot_r[k].y - rxs;
        rot_nxt[k+1].z = rot_r[k].z + {3'b0, phrr_pkg::ATAN_Q16[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_v_r <= '0;
    end else if (adv) begin
      rot_v_r <= {rot_v_r[N-1:0], ang_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) rot_r[k] <= rot_nxt[k];
      rcar_r[0] <= acar_r;
      for (int k = 1; k <= N; k++) rcar_r[k] <= rcar_r[k-1];
    end
  end

  // Undo the fold; an unrotated palm gets exact sin 0 and cos 1
  always_comb begin
    if (rot_r[N].azero) begin
      s_nxt = '0;
      c_nxt = phrr_pkg::ONE_Q30;
    end else if (rot_r[N].neg) begin
      s_nxt = -$signed(rot_r[N].y);
      c_nxt = -$signed(rot_r[N].x);
    end else begin
      s_nxt = $signed(rot_r[N].y);
      c_nxt = $signed(rot_r[N].x);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      sc_v_r  <= rot_v_r[N];
      m1_v_r  <= sc_v_r;
      m2_v_r  <= m1_v_r;
      out_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r      <= s_nxt;
      c_r      <= c_nxt;
      sc_ang_r <= rot_r[N].ang;
      scar_r   <= rcar_r[N];
    end
  end

  // Rotation products of the center offset and the half side
  assign half_side = scar_r.size[22:1];

  always_ff @(posedge clk) begin
    if (adv) begin
      oxc_r     <= $signed(scar_r.ox) * c_r;
      oys_r     <= $signed(scar_r.oy) * s_r;
      oxs_r     <= $signed(scar_r.ox) * s_r;
      oyc_r     <= $signed(scar_r.oy) * c_r;
      dc_r      <= $signed({1'b0, half_side}) * c_r;
      ds_r      <= $signed({1'b0, half_side}) * s_r;
      m1_pcx_r  <= scar_r.pcx;
      m1_pcy_r  <= scar_r.pcy;
      m1_ang_r  <= sc_ang_r;
      m1_size_r <= scar_r.size;
    end
  end

  // Round at bit 30; saturate the hand center
  always_comb begin
    sumx = $signed({oxc_r[58], oxc_r}) - $signed({oys_r[58], oys_r});
    sumy = $signed({oxs_r[58], oxs_r}) + $signed({oyc_r[58], oyc_r});
    tx   = sumx + 60'sd536870912;
    ty   = sumy + 60'sd536870912;
    hcx_nxt = sat24($signed({{2{tx[59]}}, tx[59:30]})
                    + $signed({{7{m1_pcx_r[24]}}, m1_pcx_r}));
    hcy_nxt = sat24($signed({{2{ty[59]}}, ty[59:30]})
                    + $signed({{7{m1_pcy_r[24]}}, m1_pcy_r}));
    sa = $signed({{2{dc_r[55]}}, dc_r}) + $signed({{2{ds_r[55]}}, ds_r});
    sb = $signed({{2{dc_r[55]}}, dc_r}) - $signed({{2{ds_r[55]}}, ds_r});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hcx_r     <= hcx_nxt;
      hcy_r     <= hcy_nxt;
      ra_r      <= rnd30(sa);
      rna_r     <= rnd30(58'sd0 - sa);
      rb_r      <= rnd30(sb);
      rnb_r     <= rnd30(58'sd0 - sb);
      m2_ang_r  <= m1_ang_r;
      m2_size_r <= m1_size_r;
    end
  end

  // Place the four corners around the center; hold while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ang_r  <= m2_ang_r;
      out_size_r <= m2_size_r;
      out_hcx_r  <= hcx_r;
      out_hcy_r  <= hcy_r;
      c0x_r      <= add_sat(hcx_r, rnb_r);
      c0y_r      <= add_sat(hcy_r, rna_r);
      c1x_r      <= add_sat(hcx_r, ra_r);
      c1y_r      <= add_sat(hcy_r, rnb_r);
      c2x_r      <= add_sat(hcx_r, rb_r);
      c2y_r      <= add_sat(hcy_r, ra_r);
      c3x_r      <= add_sat(hcx_r, rna_r);
      c3y_r      <= add_sat(hcy_r, rb_r);
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.angle         = out_ang_r;
  assign out_chan.hand_center_x = out_hcx_r;
  assign out_chan.hand_center_y = out_hcy_r;
  assign out_chan.hand_size     = out_size_r;
  assign out_chan.corner0_x     = c0x_r;
  assign out_chan.corner0_y     = c0y_r;
  assign out_chan.corner1_x     = c1x_r;
  assign out_chan.corner1_y     = c1y_r;
  assign out_chan.corner2_x     = c2x_r;
  assign out_chan.corner2_y     = c2y_r;
  assign out_chan.corner3_x     = c3x_r;
  assign out_chan.corner3_y     = c3y_r;

endmodule

// File: rtl/palm_to_hand_rotated_rect_top.sv
// Top level of the palm-to-hand rotated rectangle block: configuration
// registers, front, queue and back. Uses phrr_pkg, phrr_if and submodules.
//
// One palm in, one rotated hand square out. The block takes a new palm every
// clock while the result side keeps taking results. A palm passes through
// the front's two stages, the queue slot, the two CORDIC pipelines in the
// back (atan2 by vectoring, then sin/cos by rotation), the product and
// rounding stages and the output register. The four-entry queue lets the
// front keep accepting while the back is held by a stalled output. Write
// configuration only while no palm is in flight.
module palm_to_hand_rotated_rect_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  phrr_in_if.sink     in_chan,
  phrr_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]           hand_scale_r;
  logic signed [12:0]    shift_x_r;
  logic signed [12:0]    shift_y_r;
  logic                  fq_valid, fq_ready;
  phrr_pkg::front_item_t fq_item;
  logic                  qb_valid, qb_ready;
  phrr_pkg::front_item_t qb_item;

  // Write configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_scale_r <= phrr_pkg::HAND_SCALE_RST;
      shift_x_r    <= phrr_pkg::SHIFT_X_RST;
      shift_y_r    <= phrr_pkg::SHIFT_Y_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        phrr_pkg::CFG_HAND_SCALE: hand_scale_r <= cfg_wdata;
        phrr_pkg::CFG_SHIFT_X:    shift_x_r    <= cfg_wdata[12:0];
        phrr_pkg::CFG_SHIFT_Y:    shift_y_r    <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  phrr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .hand_scale     (hand_scale_r),
    .center_shift_x (shift_x_r),
    .center_shift_y (shift_y_r),
    .q_valid        (fq_valid),
    .q_ready        (fq_ready),
    .q_item         (fq_item)
  );

  phrr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  phrr_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (qb_valid),
    .in_ready (qb_ready),
    .in_item  (qb_item),
    .out_chan (out_chan)
  );

`ifndef SYNTH
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.angle >= -16'sd25736) && (out_chan.angle <= 16'sd25735))
    else $error("angle outside [-pi, pi)");

  a_empty_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.hand_size == '0) |->
      (out_chan.corner0_x == out_chan.hand_center_x) &&
      (out_chan.corner0_y == out_chan.hand_center_y) &&
      (out_chan.corner2_x == out_chan.hand_center_x) &&
      (out_chan.corner2_y == out_chan.hand_center_y))
    else $error("zero-size square has corners off its center");
`endif

endmodule
